// File: design/area_average_image_scaler_macros.svh
// Assertion macros shared by the area-average scaler.
`ifndef AREA_AVERAGE_IMAGE_SCALER_MACROS_SVH
`define AREA_AVERAGE_IMAGE_SCALER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define AAVS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AAVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/aavs_pkg.sv
// Types and constants of the area-average image scaler.
package aavs_pkg;

   // Field widths.
   localparam int DIM_W        = 9;
   localparam int COORD_W      = 8;
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 24;
   localparam int STORE_ADDR_W = 16;
   localparam int STORE_DEPTH  = 65536;

   // Datapath widths: positions in sub-pixel units, weights and sums.
   localparam int POS_W = 18;
   localparam int WGT_W = 9;
   localparam int W_W   = 18;
   localparam int ACC_W = 26;
   localparam int TOT_W = 18;

   // Serial divider: every quotient it forms is known to fit in DIV_Q_W bits.
   localparam int DIV_NUM_W = 27;
   localparam int DIV_DEN_W = 19;
   localparam int DIV_Q_W   = 9;
   localparam int DIV_CNT_W = 4;

   // Register indexes.
   localparam logic [1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_DST_HEIGHT = 2'd3;

   // Item functions.
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_COMPUTE = 1'b1;

   // Largest channel value.
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // Reset value of every size register.
   localparam logic [DIM_W-1:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic                    func;
      logic [15:0]             pixel_index;
      logic [CHAN_W-1:0]       in_red;
      logic [CHAN_W-1:0]       in_green;
      logic [CHAN_W-1:0]       in_blue;
      logic [COORD_W-1:0]      dst_x;
      logic [COORD_W-1:0]      dst_y;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] res_red;
      logic [CHAN_W-1:0] res_green;
      logic [CHAN_W-1:0] res_blue;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: design/aavs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module aavs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/aavs_div.sv
// Restoring divider that forms a short quotient one bit per cycle.
module aavs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  aavs_pkg::div_req_type div_req,
   output aavs_pkg::div_rsp_type div_rsp
);

   localparam int NW = aavs_pkg::DIV_NUM_W;
   localparam int QW = aavs_pkg::DIV_Q_W;
   localparam int CW = aavs_pkg::DIV_CNT_W;

   logic [NW-1:0] rem_ff;
   logic [NW-1:0] dsh_ff;
   logic [QW-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic          fits;

   // The shifted divisor fits into the remainder: this quotient bit is one.
   assign fits = (rem_ff >= dsh_ff);

   // Iteration count and completion strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            cnt_ff <= CW'(QW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder, shifted divisor and quotient.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.dividend;
         dsh_ff <= {div_req.divisor, {(QW-1){1'b0}}};
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         quo_ff <= {quo_ff[QW-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: design/aavs_acc.sv
// Weighting pipeline: forms pixel weights and accumulates weighted channels.
module aavs_acc (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic                                in_valid,
   input  logic [aavs_pkg::WGT_W-1:0]          wx,
   input  logic [aavs_pkg::WGT_W-1:0]          wy,
   input  logic [aavs_pkg::PIX_W-1:0]          pixel,
   output logic                                busy,
   output logic [aavs_pkg::ACC_W-1:0]          sum_red,
   output logic [aavs_pkg::ACC_W-1:0]          sum_green,
   output logic [aavs_pkg::ACC_W-1:0]          sum_blue,
   output logic [aavs_pkg::TOT_W-1:0]          sum_weight
);

   localparam int WW = aavs_pkg::W_W;
   localparam int AW = aavs_pkg::ACC_W;
   localparam int CW = aavs_pkg::CHAN_W;
   localparam int GW = aavs_pkg::WGT_W;

   logic                            vld_a_ff;
   logic                            vld_b_ff;
   logic [WW-1:0]                   w_a_ff;
   logic [aavs_pkg::PIX_W-1:0]      pix_a_ff;
   logic [WW-1:0]                   w_b_ff;
   logic [AW-1:0]                   prod_r_ff;
   logic [AW-1:0]                   prod_g_ff;
   logic [AW-1:0]                   prod_b_ff;
   logic [AW-1:0]                   acc_r_ff;
   logic [AW-1:0]                   acc_g_ff;
   logic [AW-1:0]                   acc_b_ff;
   logic [aavs_pkg::TOT_W-1:0]      tot_ff;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
      end
   end

   // Stage A forms the area weight; stage B the three weighted channels.
   always_ff @(posedge clock) begin
      w_a_ff    <= {{(WW-GW){1'b0}}, wx} * {{(WW-GW){1'b0}}, wy};
      pix_a_ff  <= pixel;
      w_b_ff    <= w_a_ff;
      prod_r_ff <= {{(AW-CW){1'b0}}, pix_a_ff[23:16]} * {{(AW-WW){1'b0}}, w_a_ff};
      prod_g_ff <= {{(AW-CW){1'b0}}, pix_a_ff[15:8]} * {{(AW-WW){1'b0}}, w_a_ff};
      prod_b_ff <= {{(AW-CW){1'b0}}, pix_a_ff[7:0]} * {{(AW-WW){1'b0}}, w_a_ff};
   end

   // Accumulators, cleared at the start of each output pixel.
   always_ff @(posedge clock) begin
      if (clear) begin
         acc_r_ff <= '0;
         acc_g_ff <= '0;
         acc_b_ff <= '0;
         tot_ff   <= '0;
      end else if (vld_b_ff) begin
         acc_r_ff <= acc_r_ff + prod_r_ff;
         acc_g_ff <= acc_g_ff + prod_g_ff;
         acc_b_ff <= acc_b_ff + prod_b_ff;
         tot_ff   <= tot_ff + w_b_ff;
      end
   end

   assign busy       = vld_a_ff | vld_b_ff;
   assign sum_red    = acc_r_ff;
   assign sum_green  = acc_g_ff;
   assign sum_blue   = acc_b_ff;
   assign sum_weight = tot_ff;

endmodule

// File: design/area_average_image_scaler.sv
// Top level of the area-average image scaler with its RGB frame store.
// A load item (func 0) writes one pixel into the frame store in the cycle it is
// accepted and the block is ready again in the next cycle; it gives no result.
// A compute item (func 1) goes through a setup step, four quotients for the window
// bounds from the shared bit-serial divider, a step to prepare the walk, one
// frame-store read per covered source pixel, a drain of the weighting pipeline,
// three quotients for the channel averages from the same divider and the result;
// if the total weight is zero, the channel quotients are skipped and the result is
// black. An output pixel outside the output image gives black in the cycle after
// acceptance, without going busy. Each result is shown on rsp_data for exactly
// one cycle, marked by rsp_valid; the receiver cannot stall it, so it must take
// every strobe. There is no clearing pass: a pixel must be loaded before a compute
// item covers it.

`include "area_average_image_scaler_macros.svh"

module area_average_image_scaler #(
   parameter int unsigned MAX_SRC_WIDTH  = 256,
   parameter int unsigned MAX_SRC_HEIGHT = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  aavs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output aavs_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [aavs_pkg::DIM_W-1:0]      csr_data
);

   localparam int DW = aavs_pkg::DIM_W;
   localparam int PW = aavs_pkg::POS_W;
   localparam int AW = aavs_pkg::STORE_ADDR_W;
   localparam int NW = aavs_pkg::DIV_NUM_W;
   localparam int EW = aavs_pkg::DIV_DEN_W;
   localparam int QW = aavs_pkg::DIV_Q_W;
   localparam int GW = aavs_pkg::WGT_W;
   localparam int XW = 17;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SETUP   = 7'b0000010,
      ST_WIN_DIV = 7'b0000100,
      ST_PREP    = 7'b0001000,
      ST_WALK    = 7'b0010000,
      ST_DRAIN   = 7'b0100000,
      ST_CH_DIV  = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      STEP_X_LO  = 3'd0,
      STEP_X_HI  = 3'd1,
      STEP_Y_LO  = 3'd2,
      STEP_Y_HI  = 3'd3,
      STEP_RED   = 3'd4,
      STEP_GREEN = 3'd5,
      STEP_BLUE  = 3'd6
   } step_type;

   // Size register as the datapath sees it: zero acts as one, large is limited.
   function automatic logic [DW-1:0] eff_size(input logic [DW-1:0] v,
                                               input int unsigned maxv);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (32'(v) > maxv) begin
         r = DW'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Channel average limited to the channel range.
   function automatic logic [aavs_pkg::CHAN_W-1:0] sat_chan(input logic [QW-1:0] q);
      logic [aavs_pkg::CHAN_W-1:0] r;
      if (q > {1'b0, aavs_pkg::CHAN_MAX}) begin
         r = aavs_pkg::CHAN_MAX;
      end else begin
         r = q[aavs_pkg::CHAN_W-1:0];
      end
      return r;
   endfunction

   function automatic step_type next_step(input step_type s);
      step_type r;
      case (s)
         STEP_X_LO:  r = STEP_X_HI;
         STEP_X_HI:  r = STEP_Y_LO;
         STEP_Y_LO:  r = STEP_Y_HI;
         STEP_RED:   r = STEP_GREEN;
         STEP_GREEN: r = STEP_BLUE;
         default:    r = STEP_RED;
      endcase
      return r;
   endfunction

   // Control registers.
   state_type state_ff;
   state_type state_in;
   step_type  step_ff;
   logic      div_go_ff;
   logic      walk_vld_ff;
   logic      rsp_valid_ff;

   // Size registers.
   logic [DW-1:0] src_width_ff;
   logic [DW-1:0] src_height_ff;
   logic [DW-1:0] dst_width_ff;
   logic [DW-1:0] dst_height_ff;

   // Per-item operands and window.
   logic [DW-1:0]                  sw_ff;
   logic [DW-1:0]                  sh_ff;
   logic [DW-1:0]                  ow_ff;
   logic [DW-1:0]                  oh_ff;
   logic [aavs_pkg::COORD_W-1:0]   dx_ff;
   logic [aavs_pkg::COORD_W-1:0]   dy_ff;
   logic [XW-1:0]                  ax_ff;
   logic [XW-1:0]                  ay_ff;
   logic [DW-1:0]                  x0_ff;
   logic [DW-1:0]                  x1_ff;
   logic [DW-1:0]                  y0_ff;
   logic [DW-1:0]                  y1_ff;
   logic [DW-1:0]                  sx_ff;
   logic [DW-1:0]                  sy_ff;
   logic [PW-1:0]                  pxs_ff;
   logic [PW-1:0]                  px0_ff;
   logic [PW-1:0]                  py0_ff;
   logic [AW-1:0]                  row_base_ff;
   logic [GW-1:0]                  wx_ff;
   logic [GW-1:0]                  wy_ff;
   logic [QW-1:0]                  q_red_ff;
   logic [QW-1:0]                  q_green_ff;
   aavs_pkg::rsp_type              rsp_data_ff;

   // Combinational helpers.
   logic [DW-1:0]              sw_eff;
   logic [DW-1:0]              sh_eff;
   logic [DW-1:0]              ow_eff;
   logic [DW-1:0]              oh_eff;
   logic                       accept;
   logic                       compute;
   logic                       outside;
   logic [PW-1:0]              bx;
   logic [PW-1:0]              by;
   logic [PW-1:0]              px1;
   logic [PW-1:0]              py1;
   logic [PW-1:0]              lo_x;
   logic [PW-1:0]              hi_x;
   logic [PW-1:0]              lo_y;
   logic [PW-1:0]              hi_y;
   logic [GW-1:0]              wx_w;
   logic [GW-1:0]              wy_w;
   logic [PW-1:0]              pxs_w;
   logic [PW-1:0]              pys_w;
   logic [PW-1:0]              rbs_w;
   logic                       col_last;
   logic                       row_last;
   logic                       drained;
   logic [AW-1:0]              rd_addr;
   logic [aavs_pkg::PIX_W-1:0] rd_data;
   logic                       ram_we;

   aavs_pkg::div_req_type div_req;
   aavs_pkg::div_rsp_type div_rsp;

   logic                               acc_busy;
   logic [aavs_pkg::ACC_W-1:0]         sum_red;
   logic [aavs_pkg::ACC_W-1:0]         sum_green;
   logic [aavs_pkg::ACC_W-1:0]         sum_blue;
   logic [aavs_pkg::TOT_W-1:0]         sum_weight;
   logic [aavs_pkg::ACC_W-1:0]         sum_sel;

   // Item acceptance and the out-of-image check.
   assign sw_eff  = eff_size(src_width_ff, MAX_SRC_WIDTH);
   assign sh_eff  = eff_size(src_height_ff, MAX_SRC_HEIGHT);
   assign ow_eff  = eff_size(dst_width_ff, 32'd511);
   assign oh_eff  = eff_size(dst_height_ff, 32'd511);
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start & ~busy;
   assign compute = (req_data.func == aavs_pkg::FUNC_COMPUTE);
   assign outside = ({1'b0, req_data.dst_x} >= ow_eff) ||
                    ({1'b0, req_data.dst_y} >= oh_eff);
   assign ram_we  = accept & (req_data.func == aavs_pkg::FUNC_LOAD);

   // Output cell ends and source cell ends in units of 1/dst size.
   assign bx  = {1'b0, ax_ff} + {{(PW-DW){1'b0}}, sw_ff};
   assign by  = {1'b0, ay_ff} + {{(PW-DW){1'b0}}, sh_ff};
   assign px1 = px0_ff + {{(PW-DW){1'b0}}, ow_ff};
   assign py1 = py0_ff + {{(PW-DW){1'b0}}, oh_ff};

   // Overlap of the current source cell with the output cell on each axis.
   always_comb begin
      lo_x = ({1'b0, ax_ff} > px0_ff) ? {1'b0, ax_ff} : px0_ff;
      hi_x = (bx < px1) ? bx : px1;
      lo_y = ({1'b0, ay_ff} > py0_ff) ? {1'b0, ay_ff} : py0_ff;
      hi_y = (by < py1) ? by : py1;
      wx_w = (hi_x > lo_x) ? GW'(hi_x - lo_x) : '0;
      wy_w = (hi_y > lo_y) ? GW'(hi_y - lo_y) : '0;
   end

   // Window start positions and the first row's raster address.
   assign pxs_w = {{(PW-DW){1'b0}}, x0_ff} * {{(PW-DW){1'b0}}, ow_ff};
   assign pys_w = {{(PW-DW){1'b0}}, y0_ff} * {{(PW-DW){1'b0}}, oh_ff};
   assign rbs_w = {{(PW-DW){1'b0}}, y0_ff} * {{(PW-DW){1'b0}}, sw_ff};

   assign col_last = (sx_ff == x1_ff);
   assign row_last = (sy_ff == y1_ff);
   assign drained  = ~walk_vld_ff & ~acc_busy;
   assign rd_addr  = row_base_ff + {{(AW-DW){1'b0}}, sx_ff};

   // Divider operands for each step.
   always_comb begin
      div_req.start    = div_go_ff;
      div_req.dividend = '0;
      div_req.divisor  = {{(EW-DW){1'b0}}, ow_ff};
      sum_sel          = sum_red;
      case (step_ff)
         STEP_X_LO: begin
            div_req.dividend = {{(NW-XW){1'b0}}, ax_ff};
         end
         STEP_X_HI: begin
            div_req.dividend = {{(NW-PW){1'b0}}, bx - PW'(1)};
         end
         STEP_Y_LO: begin
            div_req.dividend = {{(NW-XW){1'b0}}, ay_ff};
            div_req.divisor  = {{(EW-DW){1'b0}}, oh_ff};
         end
         STEP_Y_HI: begin
            div_req.dividend = {{(NW-PW){1'b0}}, by - PW'(1)};
            div_req.divisor  = {{(EW-DW){1'b0}}, oh_ff};
         end
         default: begin
            if (step_ff == STEP_GREEN) begin
               sum_sel = sum_green;
            end else if (step_ff == STEP_BLUE) begin
               sum_sel = sum_blue;
            end
            div_req.dividend = {sum_sel, 1'b0} +
                               {{(NW-aavs_pkg::TOT_W){1'b0}}, sum_weight};
            div_req.divisor  = {sum_weight, 1'b0};
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && compute && !outside) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_WIN_DIV;
         end
         ST_WIN_DIV: begin
            if (div_rsp.done && step_ff == STEP_Y_HI) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (col_last && row_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drained) begin
               state_in = (sum_weight == '0) ? ST_IDLE : ST_CH_DIV;
            end
         end
         ST_CH_DIV: begin
            if (div_rsp.done && step_ff == STEP_BLUE) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers, size registers and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_X_LO;
         div_go_ff     <= 1'b0;
         walk_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= aavs_pkg::SIZE_RESET;
         src_height_ff <= aavs_pkg::SIZE_RESET;
         dst_width_ff  <= aavs_pkg::SIZE_RESET;
         dst_height_ff <= aavs_pkg::SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         div_go_ff    <= 1'b0;
         walk_vld_ff  <= (state_ff == ST_WALK);
         rsp_valid_ff <= 1'b0;

         if (csr_we) begin
            case (csr_index)
               aavs_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
               aavs_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data;
               aavs_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
               aavs_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_data;
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept && compute && outside) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_SETUP: begin
               step_ff   <= STEP_X_LO;
               div_go_ff <= 1'b1;
            end
            ST_WIN_DIV: begin
               if (div_rsp.done && step_ff != STEP_Y_HI) begin
                  step_ff   <= next_step(step_ff);
                  div_go_ff <= 1'b1;
               end
            end
            ST_DRAIN: begin
               if (drained) begin
                  if (sum_weight == '0) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     step_ff   <= STEP_RED;
                     div_go_ff <= 1'b1;
                  end
               end
            end
            ST_CH_DIV: begin
               if (div_rsp.done) begin
                  if (step_ff == STEP_BLUE) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     step_ff   <= next_step(step_ff);
                     div_go_ff <= 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Operand, window and result registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sw_ff       <= sw_eff;
            sh_ff       <= sh_eff;
            ow_ff       <= ow_eff;
            oh_ff       <= oh_eff;
            dx_ff       <= req_data.dst_x;
            dy_ff       <= req_data.dst_y;
            rsp_data_ff <= '0;
         end
         ST_SETUP: begin
            ax_ff <= {{(XW-aavs_pkg::COORD_W){1'b0}}, dx_ff} * {{(XW-DW){1'b0}}, sw_ff};
            ay_ff <= {{(XW-aavs_pkg::COORD_W){1'b0}}, dy_ff} * {{(XW-DW){1'b0}}, sh_ff};
         end
         ST_WIN_DIV: begin
            if (div_rsp.done) begin
               case (step_ff)
                  STEP_X_LO: x0_ff <= div_rsp.quotient;
                  STEP_X_HI: x1_ff <= div_rsp.quotient;
                  STEP_Y_LO: y0_ff <= div_rsp.quotient;
                  default:   y1_ff <= div_rsp.quotient;
               endcase
            end
         end
         ST_PREP: begin
            sx_ff       <= x0_ff;
            sy_ff       <= y0_ff;
            pxs_ff      <= pxs_w;
            px0_ff      <= pxs_w;
            py0_ff      <= pys_w;
            row_base_ff <= rbs_w[AW-1:0];
         end
         ST_WALK: begin
            wx_ff <= wx_w;
            wy_ff <= wy_w;
            if (col_last) begin
               sx_ff       <= x0_ff;
               px0_ff      <= pxs_ff;
               sy_ff       <= sy_ff + DW'(1);
               py0_ff      <= py1;
               row_base_ff <= row_base_ff + {{(AW-DW){1'b0}}, sw_ff};
            end else begin
               sx_ff  <= sx_ff + DW'(1);
               px0_ff <= px1;
            end
         end
         ST_DRAIN: begin
            rsp_data_ff <= '0;
         end
         ST_CH_DIV: begin
            if (div_rsp.done) begin
               case (step_ff)
                  STEP_RED:   q_red_ff   <= div_rsp.quotient;
                  STEP_GREEN: q_green_ff <= div_rsp.quotient;
                  default: begin
                     rsp_data_ff.res_red   <= sat_chan(q_red_ff);
                     rsp_data_ff.res_green <= sat_chan(q_green_ff);
                     rsp_data_ff.res_blue  <= sat_chan(div_rsp.quotient);
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Frame store: loads write, the window walk reads.
   aavs_ram #(
      .WIDTH (aavs_pkg::PIX_W),
      .DEPTH (aavs_pkg::STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_data.pixel_index),
      .wr_data ({req_data.in_red, req_data.in_green, req_data.in_blue}),
      .rd_en   (state_ff == ST_WALK),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared serial divider for window bounds and channel averages.
   aavs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Weighting and accumulation pipeline.
   aavs_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .clear      (state_ff == ST_SETUP),
      .in_valid   (walk_vld_ff),
      .wx         (wx_ff),
      .wy         (wy_ff),
      .pixel      (rd_data),
      .busy       (acc_busy),
      .sum_red    (sum_red),
      .sum_green  (sum_green),
      .sum_blue   (sum_blue),
      .sum_weight (sum_weight)
   );

   // A result strobe only comes with the block ready for the next item.
   `AAVS_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_valid, !busy,
      "result strobe while busy")

   // A compute item either goes busy or answers black in the next cycle.
   `AAVS_ASSERT_NEXT(a_compute_progress, clock, reset,
      start && !busy && req_data.func == aavs_pkg::FUNC_COMPUTE, busy || rsp_valid,
      "compute item dropped")

   // The walk stays inside the window computed by the divider.
   `AAVS_ASSERT_NOW(a_walk_in_window, clock, reset, state_ff == ST_WALK,
      sx_ff >= x0_ff && sx_ff <= x1_ff && sy_ff >= y0_ff && sy_ff <= y1_ff,
      "walk left the source window")

   // Every source pixel inside the window carries a nonzero weight.
   `AAVS_ASSERT_NOW(a_weight_nonzero, clock, reset, walk_vld_ff,
      wx_ff != '0 && wy_ff != '0, "zero weight inside the window")

endmodule
